### sv/lkd_pkg.sv
// Shared types, seeds, feedback masks and generator step function for the descrambler.
package lkd_pkg;

    localparam logic [15:0] SEED_T = 16'h2953;
    localparam logic [15:0] SEED_U = 16'hd9c2;
    localparam logic [15:0] SEED_V = 16'h3ff1;
    localparam logic        SEED_K = 1'b1;

    localparam logic [15:0] FB_T = 16'ha740;
    localparam logic [15:0] FB_U = 16'hfb10;
    localparam logic [15:0] FB_V = 16'hb3d0;

    localparam int unsigned STEPS_PER_BYTE = 8;

    // Generator state: three shift registers and the running key bit
    typedef struct packed {
        logic [15:0] t;
        logic [15:0] u;
        logic [15:0] v;
        logic        k;
    } t_gen_state;

    // Item passed from front to back: data byte and its keystream byte
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] ks;
    } t_ks_item;

    // Handshake between front and queue, and queue and back
    typedef struct packed {
        logic     valid;
        t_ks_item item;
    } t_ks_push;

    localparam t_gen_state GEN_SEED = '{t: SEED_T, u: SEED_U, v: SEED_V, k: SEED_K};

    // Shift right and fold in the mask when a one falls out
    function automatic logic [15:0] shift_fb(input logic [15:0] r, input logic [15:0] mask);
        logic [15:0] sh;
        sh = {1'b0, r[15:1]};
        shift_fb = r[0] ? (sh ^ mask) : sh;
    endfunction

    // One generator step: update key bit from current low bits, then clock registers
    function automatic t_gen_state gen_step(input t_gen_state s);
        logic       t0;
        logic       t1;
        logic       u0;
        logic       u1;
        logic       v0;
        t_gen_state n;
        t0 = s.t[0];
        t1 = s.t[1];
        u0 = s.u[0];
        u1 = s.u[1];
        v0 = s.v[0];
        n.k = s.k ^ t1 ^ v0 ^ (u0 | u1) ^ ((t0 ^ u1 ^ v0) & (t0 ^ u0));
        n.v = (t0 == u0) ? shift_fb(s.v, FB_V) : s.v;
        n.u = (!t0) ? shift_fb(s.u, FB_U) : s.u;
        n.t = shift_fb(s.t, FB_T);
        gen_step = n;
    endfunction

endpackage

### sv/lkd_if.sv
// Valid/ready channel interfaces for scrambled input and plain output items.
interface lkd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] scrambled_byte;
    logic       last_in_block;

    modport source (output valid, output scrambled_byte, output last_in_block, input ready);
    modport sink   (input valid, input scrambled_byte, input last_in_block, output ready);
endinterface

interface lkd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] plain_byte;

    modport source (output valid, output plain_byte, input ready);
    modport sink   (input valid, input plain_byte, output ready);
endinterface

### sv/lkd_front.sv
// Front end: accepts items, runs eight generator steps and reloads seeds at end of block.
module lkd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lkd_in_if.sink            i_byte_ch,
    output lkd_pkg::t_ks_push o_push,
    input  logic              i_push_ready
);
    import lkd_pkg::*;

    t_gen_state r_gen;
    t_gen_state n_gen;
    t_gen_state w_chain [0:STEPS_PER_BYTE];
    logic [7:0] w_ks;
    logic       w_accept;

    // Chain eight generator steps; first bit lands in the msb
    assign w_chain[0] = r_gen;
    for (genvar g = 0; g < STEPS_PER_BYTE; g++) begin : g_step
        assign w_chain[g + 1] = gen_step(w_chain[g]);
        assign w_ks[STEPS_PER_BYTE - 1 - g] = w_chain[g + 1].k;
    end

    assign i_byte_ch.ready = i_push_ready;
    assign w_accept        = i_byte_ch.valid && i_push_ready;

    assign o_push.valid     = i_byte_ch.valid;
    assign o_push.item.data = i_byte_ch.scrambled_byte;
    assign o_push.item.ks   = w_ks;

    // Advance the generator, or reload seeds after the last item of a block
    always_comb begin
        n_gen = r_gen;
        if (w_accept) begin
            n_gen = i_byte_ch.last_in_block ? GEN_SEED : w_chain[STEPS_PER_BYTE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= GEN_SEED;
        end else begin
            r_gen <= n_gen;
        end
    end

endmodule

### sv/lkd_queue.sv
// Two-entry queue between front and back end.
module lkd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lkd_pkg::t_ks_push i_push,
    output logic              o_push_ready,
    output lkd_pkg::t_ks_push o_pop,
    input  logic              i_pop_ready
);
    import lkd_pkg::*;

    t_ks_item   r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign w_push       = i_push.valid && o_push_ready;
    assign o_pop.valid  = (r_count != 2'd0);
    assign o_pop.item   = r_mem[r_rd_ptr];
    assign w_pop        = o_pop.valid && i_pop_ready;

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### sv/lkd_back.sv
// Back end: XORs data with keystream into the output register.
module lkd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lkd_pkg::t_ks_push i_pop,
    output logic              o_pop_ready,
    lkd_out_if.source         o_byte_ch
);
    import lkd_pkg::*;

    logic       r_valid;
    logic [7:0] r_plain;
    logic       w_load;

    assign o_pop_ready = !r_valid || o_byte_ch.ready;
    assign w_load      = i_pop.valid && o_pop_ready;

    assign o_byte_ch.valid      = r_valid;
    assign o_byte_ch.plain_byte = r_plain;

    // Hold result until taken; load the next one in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop_ready) begin
            r_valid <= i_pop.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_plain <= i_pop.item.data ^ i_pop.item.ks;
        end
    end

endmodule

### sv/lfsr_keystream_descrambler.sv
// Top level of the three-register keystream descrambler.
//
//  channel     dir  payload                          handshake
//  i_byte_ch   in   scrambled_byte[8], last_in_block  valid/ready
//  o_byte_ch   out  plain_byte[8]                     valid/ready
//
// One item per cycle unless output stalls; items pass queue, then output register.
// The eight keystream steps per byte run in the front end in the accept cycle.
// Synchronous active-low reset loads the seeds and empties queue and output register.
// A two-entry queue absorbs up to two items while the output stalls.
module lfsr_keystream_descrambler (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lkd_in_if.sink    i_byte_ch,
    lkd_out_if.source o_byte_ch
);
    import lkd_pkg::*;

    t_ks_push w_push;
    logic     w_push_ready;
    t_ks_push w_pop;
    logic     w_pop_ready;

    lkd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_ch    (i_byte_ch),
        .o_push       (w_push),
        .i_push_ready (w_push_ready)
    );

    lkd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_pop        (w_pop),
        .i_pop_ready  (w_pop_ready)
    );

    lkd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (w_pop),
        .o_pop_ready (w_pop_ready),
        .o_byte_ch   (o_byte_ch)
    );

endmodule

### sim/testbench.sv
// Self-checking testbench for the three-register keystream descrambler.
`timescale 1ns / 100ps

module testbench;

    localparam logic [15:0] INIT_T = 16'h2953;
    localparam logic [15:0] INIT_U = 16'hd9c2;
    localparam logic [15:0] INIT_V = 16'h3ff1;
    localparam logic        INIT_K = 1'b1;
    localparam logic [15:0] TAPS_T = 16'ha740;
    localparam logic [15:0] TAPS_U = 16'hfb10;
    localparam logic [15:0] TAPS_V = 16'hb3d0;

    localparam int RANDOM_ITEMS = 1800;
    localparam int MAX_WAIT     = 13;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       end_of_block;
    } t_cipher_item;

    typedef struct {
        logic [15:0] t;
        logic [15:0] u;
        logic [15:0] v;
        logic        k;
    } t_keygen;

    logic i_clk;
    logic i_rst_n;

    lkd_in_if  in_ch ();
    lkd_out_if out_ch ();

    lfsr_keystream_descrambler i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_ch (in_ch.sink),
        .o_byte_ch (out_ch.source)
    );

    t_cipher_item cipher_pending[$];
    logic [7:0]   plain_expected[$];
    t_keygen      keygen;

    int   fail_count   = 0;
    int   stall_cycles = 0;
    int   src_wait     = 0;
    int   snk_wait     = 0;
    bit   src_calm     = 1'b0;
    bit   snk_calm     = 1'b0;
    bit   in_took      = 1'b0;
    bit   out_took     = 1'b0;
    bit   got_item;
    logic [7:0] want;

    // Generate the clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shift right and fold in the taps when a one drops out
    function automatic logic [15:0] lfsr_shift(input logic [15:0] r, input logic [15:0] taps);
        return r[0] ? ({1'b0, r[15:1]} ^ taps) : {1'b0, r[15:1]};
    endfunction

    // Run eight generator steps, XOR the keystream byte in, reseed at end of block
    function automatic logic [7:0] descramble_byte(input logic [7:0] data, input logic eob);
        logic [7:0] ks;
        logic       t0;
        logic       t1;
        logic       u0;
        logic       u1;
        logic       v0;
        ks = '0;
        for (int i = 0; i < 8; i++) begin
            t0 = keygen.t[0];
            t1 = keygen.t[1];
            u0 = keygen.u[0];
            u1 = keygen.u[1];
            v0 = keygen.v[0];
            keygen.k = keygen.k ^ t1 ^ v0 ^ (u0 | u1) ^ ((t0 ^ u1 ^ v0) & (t0 ^ u0));
            if (t0 == u0) keygen.v = lfsr_shift(keygen.v, TAPS_V);
            if (!t0) keygen.u = lfsr_shift(keygen.u, TAPS_U);
            keygen.t = lfsr_shift(keygen.t, TAPS_T);
            ks = {ks[6:0], keygen.k};
        end
        if (eob) keygen = '{t: INIT_T, u: INIT_U, v: INIT_V, k: INIT_K};
        return data ^ ks;
    endfunction

    // Draw the wait before the next item; flip now and then into a no-wait stretch
    function automatic int draw_wait(ref bit calm);
        if ($urandom_range(0, 63) == 0) calm = ($urandom_range(0, 2) == 0);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic queue_item(input logic [7:0] data, input logic eob);
        cipher_pending.push_back('{data: data, end_of_block: eob});
    endtask

    // Input driver: hold the item until accepted, then wait a drawn number of cycles
    always @(negedge i_clk) begin
        if (in_took) begin
            in_took  = 1'b0;
            src_wait = draw_wait(src_calm);
        end
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (src_wait > 0) begin
            src_wait--;
            in_ch.valid          <= 1'b0;
            in_ch.scrambled_byte <= 8'($urandom);
            in_ch.last_in_block  <= 1'($urandom);
        end else if (cipher_pending.size() > 0) begin
            in_ch.valid          <= 1'b1;
            in_ch.scrambled_byte <= cipher_pending[0].data;
            in_ch.last_in_block  <= cipher_pending[0].end_of_block;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Output ready: drop for a drawn number of cycles after each item
    always @(negedge i_clk) begin
        if (out_took) begin
            out_took = 1'b0;
            snk_wait = draw_wait(snk_calm);
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (snk_wait > 0) begin
            snk_wait--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Monitor: predict on input accept, check on output accept, watch for stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            got_item = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                plain_expected.push_back(descramble_byte(in_ch.scrambled_byte,
                                                         in_ch.last_in_block));
                void'(cipher_pending.pop_front());
                in_took  = 1'b1;
                got_item = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                out_took = 1'b1;
                got_item = 1'b1;
                if (plain_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected output item 0x%02h",
                                              out_ch.plain_byte));
                end else begin
                    want = plain_expected.pop_front();
                    if (out_ch.plain_byte !== want)
                        report_mismatch($sformatf("plain_byte 0x%02h, expected 0x%02h",
                                                  out_ch.plain_byte, want));
                end
            end
            stall_cycles = got_item ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ERROR @%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int total;
        int len;
        in_ch.valid          = 1'b0;
        in_ch.scrambled_byte = '0;
        in_ch.last_in_block  = 1'b0;
        out_ch.ready         = 1'b0;
        i_rst_n              = 1'b0;
        keygen = '{t: INIT_T, u: INIT_U, v: INIT_V, k: INIT_K};

        // Directed: field extremes, a short block, single-byte blocks back to back
        queue_item(8'h00, 1'b0);
        queue_item(8'hff, 1'b0);
        queue_item(8'h80, 1'b0);
        queue_item(8'h01, 1'b0);
        queue_item(8'h55, 1'b1);
        queue_item(8'haa, 1'b1);
        queue_item(8'h00, 1'b1);
        queue_item(8'hff, 1'b1);
        for (int i = 0; i < 12; i++) queue_item(8'(8'h11 * i), 1'b0);
        queue_item(8'h7f, 1'b0);
        queue_item(8'hfe, 1'b1);

        // Random blocks: mostly short, some long enough to run the registers deep
        total = 0;
        while (total < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                              : $urandom_range(1, 40);
            for (int j = 0; j < len; j++) queue_item(8'($urandom), j == len - 1);
            total += len;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cipher_pending.size() > 0 || plain_expected.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
